// ----- rtl/core/flc_pkg.sv -----
// Shared types and constants for the flash controller with key unlock.
package flc_pkg;

    // configuration port
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE  = 1'd1;
    localparam logic [CFG_W-1:0] CFG_FLASH_SIZE_RST = 17'h10000;
    localparam logic [CFG_W-1:0] CFG_PAGE_SIZE_RST  = 17'd128;

    // erase block size: a sector is eight pages
    localparam int BLK_W = CFG_W + 3;

    localparam int FLASH_BYTES_DEF = 65536;

    // access codes
    localparam logic [1:0] OP_MEM_RD = 2'd0;
    localparam logic [1:0] OP_MEM_WR = 2'd1;
    localparam logic [1:0] OP_CTL_RD = 2'd2;
    localparam logic [1:0] OP_CTL_WR = 2'd3;

    // control block offsets
    localparam logic [31:0] CTL_ACR  = 32'h00;
    localparam logic [31:0] CTL_KEYR = 32'h08;
    localparam logic [31:0] CTL_SR   = 32'h10;
    localparam logic [31:0] CTL_CR   = 32'h14;
    localparam logic [31:0] CTL_OPTR = 32'h20;
    localparam logic [31:0] CTL_SECR = 32'h24;
    localparam logic [31:0] CTL_WRPR = 32'h2C;

    localparam logic [31:0] KEY_FIRST  = 32'h4567_0123;
    localparam logic [31:0] KEY_SECOND = 32'hCDEF_89AB;

    localparam int SR_EOP_BIT    = 0;
    localparam int SR_WRPERR_BIT = 4;
    localparam int CR_PG_BIT     = 0;
    localparam int CR_PER_BIT    = 1;
    localparam int CR_MER_BIT    = 2;
    localparam int CR_SER_BIT    = 11;
    localparam int CR_LOCK_BIT   = 31;
    localparam logic [31:0] CR_LOCK_VAL = 32'h8000_0000;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] offset;
        logic [2:0]  access_size;
        logic [31:0] write_data;
    } flc_cmd_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] read_data;
    } flc_rsp_t;

    typedef struct packed {
        logic lock;
        logic ser;
        logic mer;
        logic per;
        logic pg;
    } flc_ctl_t;

    typedef struct packed {
        logic eop;
        logic wrperr;
    } flc_stat_set_t;

endpackage

// ----- rtl/core/flc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module flc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/flc_rem.sv -----
// Restoring remainder unit, one dividend bit per cycle.
module flc_rem #(
    parameter int DW = 16,
    parameter int VW = 20
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [VW-1:0] rem
);
    localparam int CW = $clog2(DW + 1);

    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] dvd_reg, dvd_next;
    logic [VW-1:0] dvs_reg, dvs_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW:0]   trial;

    always_comb
    begin
        trial     = {rem_reg, dvd_reg[DW-1]};
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            dvd_next = dividend;
            dvs_next = divisor;
            rem_next = '0;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = VW'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_next = trial[VW-1:0];
            end
            dvd_next = {dvd_reg[DW-2:0], 1'b0};
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(DW - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ----- rtl/core/flc_regs.sv -----
// Control register block: status, control, key unlock sequence, misc words.
module flc_regs (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr,
    input  logic [31:0]           addr,
    input  logic [31:0]           wdata,
    input  flc_pkg::flc_stat_set_t stat_set,
    output logic [31:0]           rdata,
    output flc_pkg::flc_ctl_t     ctl
);
    import flc_pkg::*;

    logic [31:0] acr_reg, acr_next;
    logic [31:0] cr_reg, cr_next;
    logic [31:0] optr_reg, optr_next;
    logic [31:0] secr_reg, secr_next;
    logic [31:0] wrpr_reg, wrpr_next;
    logic        eop_reg, eop_next;
    logic        wrperr_reg, wrperr_next;
    logic        stage_reg, stage_next;
    logic [31:0] sr_view;
    logic        sr_wr;

    always_comb
    begin
        sr_view                = '0;
        sr_view[SR_EOP_BIT]    = eop_reg;
        sr_view[SR_WRPERR_BIT] = wrperr_reg;
        case (addr)
            CTL_ACR:  rdata = acr_reg;
            CTL_SR:   rdata = sr_view;
            CTL_CR:   rdata = cr_reg;
            CTL_OPTR: rdata = optr_reg;
            CTL_SECR: rdata = secr_reg;
            CTL_WRPR: rdata = wrpr_reg;
            default:  rdata = '0;
        endcase
    end

    always_comb
    begin
        acr_next   = acr_reg;
        cr_next    = cr_reg;
        optr_next  = optr_reg;
        secr_next  = secr_reg;
        wrpr_next  = wrpr_reg;
        stage_next = stage_reg;
        sr_wr      = 1'b0;
        if (wr)
        begin
            case (addr)
                CTL_ACR:  acr_next = wdata;
                CTL_KEYR:
                begin
                    // keys only count while locked; a wrong key restarts
                    if (cr_reg[CR_LOCK_BIT])
                    begin
                        if (!stage_reg && wdata == KEY_FIRST)
                        begin
                            stage_next = 1'b1;
                        end
                        else if (stage_reg && wdata == KEY_SECOND)
                        begin
                            cr_next    = cr_reg & ~CR_LOCK_VAL;
                            stage_next = 1'b0;
                        end
                        else
                        begin
                            stage_next = 1'b0;
                        end
                    end
                end
                CTL_SR:   sr_wr = 1'b1;
                CTL_CR:   cr_next = cr_reg[CR_LOCK_BIT] ? CR_LOCK_VAL : wdata;
                CTL_OPTR: optr_next = wdata;
                CTL_SECR: secr_next = wdata;
                CTL_WRPR: wrpr_next = wdata;
                default:  sr_wr = 1'b0;
            endcase
        end
        eop_next    = (eop_reg & ~(sr_wr & wdata[SR_EOP_BIT])) | stat_set.eop;
        wrperr_next = (wrperr_reg & ~(sr_wr & wdata[SR_WRPERR_BIT])) | stat_set.wrperr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acr_reg    <= '0;
            cr_reg     <= CR_LOCK_VAL;
            optr_reg   <= '0;
            secr_reg   <= '0;
            wrpr_reg   <= '0;
            eop_reg    <= 1'b0;
            wrperr_reg <= 1'b0;
            stage_reg  <= 1'b0;
        end
        else
        begin
            acr_reg    <= acr_next;
            cr_reg     <= cr_next;
            optr_reg   <= optr_next;
            secr_reg   <= secr_next;
            wrpr_reg   <= wrpr_next;
            eop_reg    <= eop_next;
            wrperr_reg <= wrperr_next;
            stage_reg  <= stage_next;
        end
    end

    assign ctl.lock = cr_reg[CR_LOCK_BIT];
    assign ctl.ser  = cr_reg[CR_SER_BIT];
    assign ctl.mer  = cr_reg[CR_MER_BIT];
    assign ctl.per  = cr_reg[CR_PER_BIT];
    assign ctl.pg   = cr_reg[CR_PG_BIT];

endmodule

// ----- rtl/core/flash_controller_with_unlock_top.sv -----
// Flash controller top: access sequencer, flash byte-lane RAMs, erase walker.
// Control, rejected or refused accesses give their result straight from the
// accept; a flash read passes through S_READ, a word program through S_PROG.
// Mass erase walks from word 0 up to the access limit; page or sector erase first
// runs the remainder unit, then one RAM word per cycle. One transaction at a time;
// the next one can be accepted in the result cycle. Reset sweeps the array to 0xFF.
module flash_controller_with_unlock_top #(
    parameter int FLASH_BYTES = flc_pkg::FLASH_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  flc_pkg::flc_cmd_t               cmd,
    output logic                            busy,
    output logic                            done,
    output flc_pkg::flc_rsp_t               rsp,
    input  logic                            cfg_write,
    input  logic [flc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [flc_pkg::CFG_W-1:0]       cfg_data
);
    import flc_pkg::*;

    localparam int WORDS = (FLASH_BYTES + 3) / 4;
    localparam int WW    = $clog2(WORDS);
    localparam int AW    = $clog2(FLASH_BYTES);
    localparam int LW    = $clog2(FLASH_BYTES + 1);
    localparam int EW    = ((AW > BLK_W) ? AW : BLK_W) + 2;
    localparam int CMPW  = (CFG_W > LW) ? CFG_W : LW;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_PROG  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_ERASE = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [WW-1:0]    word_reg, word_next;
    logic             done_reg, done_next;
    logic [CFG_W-1:0] fsize_reg, fsize_next;
    logic [CFG_W-1:0] psize_reg, psize_next;
    flc_rsp_t         rsp_reg, rsp_next;
    logic [EW-1:0]    start_reg, start_next;
    logic [EW-1:0]    end_reg, end_next;
    logic [AW-1:0]    off_reg, off_next;
    logic [BLK_W-1:0] block_reg, block_next;
    logic [1:0]       lo_reg, lo_next;
    logic [2:0]       size_reg, size_next;
    logic [31:0]      data_reg, data_next;

    logic [LW-1:0]    lim;
    logic             accept;
    logic             fits;
    logic [BLK_W-1:0] page;
    logic [BLK_W-1:0] blk_sel;
    logic             rem_start;
    logic             rem_done;
    logic [BLK_W-1:0] rem_val;
    logic [EW-1:0]    div_start;
    logic [EW-1:0]    div_end;
    logic [EW-1:0]    word_byte;
    logic [WW-1:0]    ram_raddr;
    logic [3:0]       lane_we;
    logic [7:0]       lane_wdata [4];
    logic [7:0]       lane_rdata [4];
    logic [31:0]      word_rd;
    logic [31:0]      word_sh;
    logic [EW-1:0]    lane_addr [4];
    logic             regs_wr;
    logic [31:0]      regs_rdata;
    flc_ctl_t         ctl;
    flc_stat_set_t    stat_set;

    assign accept = start && (state_reg == S_IDLE);

    // access limit: smaller of configured size and the array
    assign lim = (CMPW'(fsize_reg) > CMPW'(FLASH_BYTES)) ? LW'(FLASH_BYTES) : LW'(fsize_reg);

    assign fits = (cmd.access_size inside {3'd1, 3'd2, 3'd4})
               && ({1'b0, cmd.offset} + 33'(cmd.access_size) <= 33'(lim))
               && ((cmd.offset[1:0] & (cmd.access_size[1:0] - 2'd1)) == 2'd0);

    assign page    = (psize_reg == '0) ? BLK_W'(1) : BLK_W'(psize_reg);
    assign blk_sel = ctl.per ? page : {page[BLK_W-4:0], 3'b000};

    assign regs_wr = accept && cmd.op == OP_CTL_WR && cmd.access_size == 3'd4;

    assign ram_raddr = cmd.offset[WW+1:2];
    assign word_rd   = {lane_rdata[3], lane_rdata[2], lane_rdata[1], lane_rdata[0]};
    assign word_sh   = word_rd >> {lo_reg, 3'b000};
    assign word_byte = EW'({word_reg, 2'b00});

    assign div_start = EW'(off_reg) - EW'(rem_val);
    always_comb
    begin
        div_end = div_start + EW'(block_reg);
        if (div_end > EW'(lim))
        begin
            div_end = EW'(lim);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            lane_addr[i]  = EW'({word_reg, 2'(i)});
            lane_wdata[i] = (state_reg == S_PROG) ? (lane_rdata[i] & data_reg[8*i +: 8])
                                                  : 8'hFF;
            case (state_reg)
                S_CLEAR: lane_we[i] = 1'b1;
                S_PROG:  lane_we[i] = 1'b1;
                S_ERASE: lane_we[i] = (lane_addr[i] >= start_reg) && (lane_addr[i] < end_reg);
                default: lane_we[i] = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        word_next  = word_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        start_next = start_reg;
        end_next   = end_reg;
        off_next   = off_reg;
        block_next = block_reg;
        lo_next    = lo_reg;
        size_next  = size_reg;
        data_next  = data_reg;
        rem_start  = 1'b0;
        stat_set   = '0;
        fsize_next = fsize_reg;
        psize_next = psize_reg;

        if (cfg_write)
        begin
            case (cfg_index)
                CFG_FLASH_SIZE: fsize_next = cfg_data;
                CFG_PAGE_SIZE:  psize_next = cfg_data;
                default:        fsize_next = fsize_reg;
            endcase
        end

        case (state_reg)
            S_CLEAR:
            begin
                word_next = word_reg + WW'(1);
                if (word_reg == WW'(WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    rsp_next  = '0;
                    lo_next   = cmd.offset[1:0];
                    size_next = cmd.access_size;
                    data_next = cmd.write_data;
                    word_next = ram_raddr;
                    case (cmd.op)
                        OP_MEM_RD:
                        begin
                            if (fits)
                            begin
                                state_next = S_READ;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        OP_MEM_WR:
                        begin
                            if (!fits)
                            begin
                                done_next = 1'b1;
                            end
                            else if (ctl.lock)
                            begin
                                stat_set.wrperr = 1'b1;
                                rsp_next.ok     = 1'b1;
                                done_next       = 1'b1;
                            end
                            else if (ctl.mer)
                            begin
                                start_next = '0;
                                end_next   = EW'(lim);
                                word_next  = '0;
                                state_next = S_ERASE;
                            end
                            else if (ctl.per || ctl.ser)
                            begin
                                off_next   = cmd.offset[AW-1:0];
                                block_next = blk_sel;
                                rem_start  = 1'b1;
                                state_next = S_DIV;
                            end
                            else if (ctl.pg && cmd.access_size == 3'd4)
                            begin
                                state_next = S_PROG;
                            end
                            else
                            begin
                                stat_set.wrperr = 1'b1;
                                rsp_next.ok     = 1'b1;
                                done_next       = 1'b1;
                            end
                        end
                        default:
                        begin
                            // control block: only word accesses, any offset
                            done_next = 1'b1;
                            if (cmd.access_size == 3'd4)
                            begin
                                rsp_next.ok = 1'b1;
                                if (cmd.op == OP_CTL_RD)
                                begin
                                    rsp_next.read_data = regs_rdata;
                                end
                            end
                        end
                    endcase
                end
            end
            S_READ:
            begin
                rsp_next.ok = 1'b1;
                case (size_reg)
                    3'd1:    rsp_next.read_data = {24'd0, word_sh[7:0]};
                    3'd2:    rsp_next.read_data = {16'd0, word_sh[15:0]};
                    default: rsp_next.read_data = word_sh;
                endcase
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_PROG:
            begin
                stat_set.eop = 1'b1;
                rsp_next.ok  = 1'b1;
                done_next    = 1'b1;
                state_next   = S_IDLE;
            end
            S_DIV:
            begin
                if (rem_done)
                begin
                    start_next = div_start;
                    end_next   = div_end;
                    word_next  = div_start[WW+1:2];
                    state_next = S_ERASE;
                end
            end
            S_ERASE:
            begin
                word_next = word_reg + WW'(1);
                if (word_byte + EW'(4) >= end_reg)
                begin
                    stat_set.eop = 1'b1;
                    rsp_next.ok  = 1'b1;
                    done_next    = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            word_reg  <= '0;
            done_reg  <= 1'b0;
            fsize_reg <= CFG_FLASH_SIZE_RST;
            psize_reg <= CFG_PAGE_SIZE_RST;
        end
        else
        begin
            state_reg <= state_next;
            word_reg  <= word_next;
            done_reg  <= done_next;
            fsize_reg <= fsize_next;
            psize_reg <= psize_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg   <= rsp_next;
        start_reg <= start_next;
        end_reg   <= end_next;
        off_reg   <= off_next;
        block_reg <= block_next;
        lo_reg    <= lo_next;
        size_reg  <= size_next;
        data_reg  <= data_next;
    end

    for (genvar g = 0; g < 4; g++)
    begin : g_lane
        flc_ram #(
            .WIDTH (8),
            .DEPTH (WORDS)
        ) u_lane (
            .clk   (clk),
            .we    (lane_we[g]),
            .waddr (word_reg),
            .wdata (lane_wdata[g]),
            .raddr (ram_raddr),
            .rdata (lane_rdata[g])
        );
    end

    flc_rem #(
        .DW (AW),
        .VW (BLK_W)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (cmd.offset[AW-1:0]),
        .divisor  (blk_sel),
        .done     (rem_done),
        .rem      (rem_val)
    );

    flc_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (regs_wr),
        .addr     (cmd.offset),
        .wdata    (cmd.write_data),
        .stat_set (stat_set),
        .rdata    (regs_rdata),
        .ctl      (ctl)
    );

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) != S_IDLE) || $past(start))
        else $error("result without a transaction in flight");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> lane_we == 4'b0000)
        else $error("flash write while idle");

    a_rem_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        rem_done |-> state_reg == S_DIV)
        else $error("remainder done outside erase setup");

    a_erase_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ERASE |-> word_byte < end_reg)
        else $error("erase walker past end of range");

endmodule
